// ----- hw/rtl/bu3_pkg.sv -----
// Shared types and constants for the bilinear 3x upscaler.
`timescale 1ns / 1ps

package bu3_pkg;

    localparam int CFG_DATA_W    = 11;
    localparam int PIXEL_W       = 32;
    localparam int COORD_W       = 12;
    localparam int ROW_CNT_W     = 10;
    localparam int OUT_TDATA_W   = 56;
    localparam int MAX_LOW_ROWS  = 1024;
    localparam int MIN_LOW_SIZE  = 2;
    localparam int RESET_COLUMNS = 320;
    localparam int RESET_ROWS    = 240;

    // floor(v / 9) equals (v * RECIP_9) >> RECIP_SHIFT for every v below 32768.
    localparam int RECIP_9       = 7282;
    localparam int RECIP_SHIFT   = 16;

    typedef enum logic {
        CFG_LOW_COLUMNS = 1'b0,
        CFG_LOW_ROWS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] fy;
        logic [1:0] fx;
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

// ----- hw/rtl/bilinear_upscale_by_three_core.sv -----
// Top level of the bilinear 3x upscaler: control sequencer, row memory and output register.
//
//   Channel   Dir   Signals                         Content
//   s_        in    s_tvalid s_tready s_tdata[31:0] low-resolution pixel
//   m_        out   m_tvalid m_tready m_tdata[55:0] output pixel with coordinates
//                   m_tlast m_tuser                 run end, frame end
//   cfg_      in    cfg_we cfg_index cfg_wdata      low_columns, low_rows
//
// An input pixel completes 9, 18 or 36 output pixels, or none; while the output is
// not stalled, one output leaves per cycle from the single output register.
// The row memory is read and written in the acceptance cycle and its data is ready
// in the next one. Reset is synchronous and clears the counters, the edge pixels,
// the sequencer and the output valid; the row memory is not cleared.
// A stalled output holds the sequencer; the next input is taken while the last
// result of the previous one still waits.
`timescale 1ns / 1ps

module bilinear_upscale_by_three_core #(
    parameter int MAX_LOW_COLUMNS = 1024,
    parameter int CHANNELS        = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bu3_pkg::PIXEL_W-1:0]        s_tdata,   // [31:0] pixel_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bu3_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [11:0] out_x, [23:12] out_y,
                                                          // [55:24] pixel_out
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] frame_end
    input  logic                               cfg_we,
    input  bu3_pkg::cfg_index_t                cfg_index,
    input  logic [bu3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = (MAX_LOW_COLUMNS > 1) ? $clog2(MAX_LOW_COLUMNS) : 1;
    localparam int WW     = $clog2(MAX_LOW_COLUMNS + 1);
    localparam int CLAMP_W = 13;
    localparam int RW     = bu3_pkg::ROW_CNT_W + 1;

    logic [bu3_pkg::CFG_DATA_W-1:0] low_columns_reg;
    logic [bu3_pkg::CFG_DATA_W-1:0] low_rows_reg;

    bu3_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]             col_cnt_reg;
    logic [bu3_pkg::ROW_CNT_W-1:0] row_cnt_reg;
    logic [ADDR_W-1:0]             c_reg;
    logic [bu3_pkg::ROW_CNT_W-1:0] r_reg;
    logic [bu3_pkg::PIXEL_W-1:0]   cur_reg;
    logic [bu3_pkg::PIXEL_W-1:0]   ul_reg;
    logic [bu3_pkg::PIXEL_W-1:0]   left_reg;
    logic [3:0]                    mask_reg, mask_next;
    bu3_pkg::phase_t               phase_reg, phase_next;

    logic                             m_tvalid_reg;
    logic [bu3_pkg::OUT_TDATA_W-1:0]  m_tdata_reg;
    logic                             m_tlast_reg;
    logic                             m_tuser_reg;

    logic [CLAMP_W-1:0]            cols_clamp;
    logic [CLAMP_W-1:0]            rows_clamp;
    logic [WW-1:0]                 width;
    logic [RW-1:0]                 height;
    logic [ADDR_W-1:0]             c_now;
    logic [bu3_pkg::ROW_CNT_W-1:0] r_now;
    logic                          last_col;
    logic                          last_row;
    logic                          accept;

    logic [bu3_pkg::PIXEL_W-1:0]   up_pix;
    logic [3:0]                    blk;
    logic [bu3_pkg::PIXEL_W-1:0]   pa, pb, pc, pd;
    logic [bu3_pkg::PIXEL_W-1:0]   blend_pix;
    logic [bu3_pkg::COORD_W-1:0]   bc, br;
    logic [bu3_pkg::COORD_W-1:0]   out_x, out_y;
    logic                          emit;
    logic                          blk_done;
    logic                          done;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_columns_reg <= bu3_pkg::CFG_DATA_W'(bu3_pkg::RESET_COLUMNS);
            low_rows_reg    <= bu3_pkg::CFG_DATA_W'(bu3_pkg::RESET_ROWS);
        end else if (cfg_we) begin
            unique case (cfg_index)
                bu3_pkg::CFG_LOW_COLUMNS: low_columns_reg <= cfg_wdata;
                bu3_pkg::CFG_LOW_ROWS:    low_rows_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_clamp = CLAMP_W'(low_columns_reg);
        if (cols_clamp < CLAMP_W'(bu3_pkg::MIN_LOW_SIZE)) begin
            cols_clamp = CLAMP_W'(bu3_pkg::MIN_LOW_SIZE);
        end else if (cols_clamp > CLAMP_W'(MAX_LOW_COLUMNS)) begin
            cols_clamp = CLAMP_W'(MAX_LOW_COLUMNS);
        end
        rows_clamp = CLAMP_W'(low_rows_reg);
        if (rows_clamp < CLAMP_W'(bu3_pkg::MIN_LOW_SIZE)) begin
            rows_clamp = CLAMP_W'(bu3_pkg::MIN_LOW_SIZE);
        end else if (rows_clamp > CLAMP_W'(bu3_pkg::MAX_LOW_ROWS)) begin
            rows_clamp = CLAMP_W'(bu3_pkg::MAX_LOW_ROWS);
        end
    end

    assign width  = WW'(cols_clamp);
    assign height = RW'(rows_clamp);

    assign c_now = (WW'(col_cnt_reg) < width - WW'(1)) ? col_cnt_reg
                                                        : ADDR_W'(width - WW'(1));
    assign r_now = (RW'(row_cnt_reg) < height - RW'(1)) ? row_cnt_reg
                                                         : bu3_pkg::ROW_CNT_W'(height - RW'(1));
    assign last_col = (WW'(c_now) == width - WW'(1));
    assign last_row = (RW'(r_now) == height - RW'(1));

    assign s_tready = (state_reg == bu3_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    bu3_row_mem #(
        .DEPTH  (MAX_LOW_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_row_mem (
        .aclk  (aclk),
        .en    (accept),
        .addr  (c_now),
        .wdata (s_tdata),
        .rdata (up_pix)
    );

    // The lowest pending block is the one being emitted.
    assign blk = mask_reg & (~mask_reg + 4'd1);

    always_comb begin
        pa = cur_reg;
        pb = cur_reg;
        pc = cur_reg;
        pd = cur_reg;
        bc = bu3_pkg::COORD_W'(c_reg);
        br = bu3_pkg::COORD_W'(r_reg);
        priority if (blk[0]) begin
            pa = ul_reg;
            pb = up_pix;
            pc = left_reg;
            bc = bu3_pkg::COORD_W'(c_reg) - bu3_pkg::COORD_W'(1);
            br = bu3_pkg::COORD_W'(r_reg) - bu3_pkg::COORD_W'(1);
        end else if (blk[1]) begin
            pa = up_pix;
            pb = up_pix;
            br = bu3_pkg::COORD_W'(r_reg) - bu3_pkg::COORD_W'(1);
        end else if (blk[2]) begin
            pa = left_reg;
            pc = left_reg;
            bc = bu3_pkg::COORD_W'(c_reg) - bu3_pkg::COORD_W'(1);
        end else begin
            pa = cur_reg;
        end
    end

    assign out_x = (bc << 1) + bc + bu3_pkg::COORD_W'(phase_reg.fx);
    assign out_y = (br << 1) + br + bu3_pkg::COORD_W'(phase_reg.fy);

    bu3_blend #(
        .CHANNELS (CHANNELS)
    ) u_blend (
        .pix_a (pa),
        .pix_b (pb),
        .pix_c (pc),
        .pix_d (pd),
        .phase (phase_reg),
        .pixel (blend_pix)
    );

    assign emit     = (state_reg == bu3_pkg::ST_EMIT) && (mask_reg != 4'd0)
                      && (!m_tvalid_reg || m_tready);
    assign blk_done = (phase_reg.fx == 2'd2) && (phase_reg.fy == 2'd2);

    always_comb begin
        mask_next  = mask_reg;
        phase_next = phase_reg;
        if (accept) begin
            mask_next  = {last_row && last_col,
                          last_row && (c_now != '0),
                          (r_now != '0) && last_col,
                          (r_now != '0) && (c_now != '0)};
            phase_next = '0;
        end else if (emit) begin
            if (phase_reg.fx == 2'd2) begin
                phase_next.fx = 2'd0;
                if (phase_reg.fy == 2'd2) begin
                    phase_next.fy = 2'd0;
                    mask_next     = mask_reg & ~blk;
                end else begin
                    phase_next.fy = phase_reg.fy + 2'd1;
                end
            end else begin
                phase_next.fx = phase_reg.fx + 2'd1;
            end
        end
    end

    assign done = (state_reg == bu3_pkg::ST_EMIT) && (mask_next == 4'd0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bu3_pkg::ST_IDLE: if (accept) state_next = bu3_pkg::ST_EMIT;
            bu3_pkg::ST_EMIT: if (done)   state_next = bu3_pkg::ST_IDLE;
            default:                      state_next = bu3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bu3_pkg::ST_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            ul_reg      <= '0;
            left_reg    <= '0;
            mask_reg    <= '0;
            phase_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            if (accept) begin
                if (last_col) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_row ? '0 : r_now + bu3_pkg::ROW_CNT_W'(1);
                end else begin
                    col_cnt_reg <= c_now + ADDR_W'(1);
                    row_cnt_reg <= r_now;
                end
            end
            if (done) begin
                ul_reg   <= up_pix;
                left_reg <= cur_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg <= s_tdata;
            c_reg   <= c_now;
            r_reg   <= r_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {blend_pix, out_y, out_x};
            m_tlast_reg <= blk_done && (mask_reg == blk);
            m_tuser_reg <= blk_done && blk[3];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_frame_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without run end");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while the previous item is still in work");

    a_idle_nothing_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bu3_pkg::ST_IDLE |-> mask_reg == 4'd0)
        else $error("blocks pending while idle");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:12] <= 12'd3071)
        else $error("output row out of range");
`endif

endmodule

// ----- hw/rtl/bu3_row_mem.sv -----
// Single-port read-first memory that holds the previous low-resolution row.
`timescale 1ns / 1ps

module bu3_row_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [bu3_pkg::PIXEL_W-1:0] wdata,
    output logic [bu3_pkg::PIXEL_W-1:0] rdata
);

    logic [bu3_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [bu3_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bu3_blend.sv -----
// Per-channel bilinear weighting of four neighbors and exact division by nine.
`timescale 1ns / 1ps

module bu3_blend #(
    parameter int CHANNELS = 3
) (
    input  logic [bu3_pkg::PIXEL_W-1:0] pix_a,
    input  logic [bu3_pkg::PIXEL_W-1:0] pix_b,
    input  logic [bu3_pkg::PIXEL_W-1:0] pix_c,
    input  logic [bu3_pkg::PIXEL_W-1:0] pix_d,
    input  bu3_pkg::phase_t             phase,
    output logic [bu3_pkg::PIXEL_W-1:0] pixel
);

    localparam int NUM_BYTES = bu3_pkg::PIXEL_W / 8;

    logic [1:0] wx;
    logic [1:0] wy;

    assign wx = 2'd3 - phase.fx;
    assign wy = 2'd3 - phase.fy;

    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_chan
        if (k < CHANNELS) begin : g_used
            logic [9:0]  top;
            logic [9:0]  bot;
            logic [11:0] sum;
            logic [24:0] prod;

            assign top  = 10'(wx) * 10'(pix_a[8*k +: 8]) + 10'(phase.fx) * 10'(pix_b[8*k +: 8]);
            assign bot  = 10'(wx) * 10'(pix_c[8*k +: 8]) + 10'(phase.fx) * 10'(pix_d[8*k +: 8]);
            assign sum  = 12'(wy) * 12'(top) + 12'(phase.fy) * 12'(bot);
            assign prod = 25'(sum) * 25'(bu3_pkg::RECIP_9);
            assign pixel[8*k +: 8] = prod[bu3_pkg::RECIP_SHIFT +: 8];
        end else begin : g_unused
            assign pixel[8*k +: 8] = 8'd0;
        end
    end

endmodule

// ----- dv/bilinear_upscale_by_three_core_tb.sv -----
// Self-checking testbench for the bilinear 3x upscaler core.
`timescale 1ns / 1ps

module bilinear_upscale_by_three_core_tb;

    localparam int          MAX_LOW_COLUMNS = 1024;
    localparam int          CHANNELS        = 3;
    localparam int          RANDOM_ITEMS    = 170;
    localparam int          DRAIN_CYCLES    = 8;
    localparam longint      CYCLE_LIMIT     = 1_000_000;

    typedef struct packed {
        logic [bu3_pkg::COORD_W-1:0] x;
        logic [bu3_pkg::COORD_W-1:0] y;
        logic [bu3_pkg::PIXEL_W-1:0] pixel;
        logic                        run_end;
        logic                        frame_end;
    } upscaled_px_t;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [bu3_pkg::PIXEL_W-1:0]         s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [bu3_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                m_tlast;
    logic                                m_tuser;
    logic                                cfg_we    = 1'b0;
    bu3_pkg::cfg_index_t                 cfg_index = bu3_pkg::CFG_LOW_COLUMNS;
    logic [bu3_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

    // Predictor state.
    logic [bu3_pkg::CFG_DATA_W-1:0]  low_cols_reg = bu3_pkg::CFG_DATA_W'(bu3_pkg::RESET_COLUMNS);
    logic [bu3_pkg::CFG_DATA_W-1:0]  low_rows_reg = bu3_pkg::CFG_DATA_W'(bu3_pkg::RESET_ROWS);
    logic [bu3_pkg::PIXEL_W-1:0]     row_store [MAX_LOW_COLUMNS];
    logic [bu3_pkg::PIXEL_W-1:0]     upper_left_px = '0;
    logic [bu3_pkg::PIXEL_W-1:0]     left_px = '0;
    int unsigned                     col_cnt = 0;
    int unsigned                     row_cnt = 0;

    logic [bu3_pkg::PIXEL_W-1:0]     pixel_q[$];
    upscaled_px_t                    pending_out_px[$];
    upscaled_px_t                    got_px;
    upscaled_px_t                    want_px;

    int unsigned             queued_count = 0;
    int unsigned             accepted_count = 0;
    int unsigned             checked_count = 0;
    int unsigned             mismatch_count = 0;
    int unsigned             reg_writes = 0;
    int unsigned             burst_left = 0;
    int unsigned             gap_left = 0;
    int unsigned             ready_span = 0;
    rx_mode_t                ready_mode = RX_STEADY;
    longint                  cycle_count = 0;

    bilinear_upscale_by_three_core #(
        .MAX_LOW_COLUMNS(MAX_LOW_COLUMNS),
        .CHANNELS       (CHANNELS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned eff_size(logic [bu3_pkg::CFG_DATA_W-1:0] v,
                                             int unsigned hi);
        if (v < bu3_pkg::MIN_LOW_SIZE) return bu3_pkg::MIN_LOW_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [bu3_pkg::PIXEL_W-1:0] blend3x(
        input logic [bu3_pkg::PIXEL_W-1:0] a, b, c, d,
        input int unsigned fy, fx);
        logic [bu3_pkg::PIXEL_W-1:0] res;
        int unsigned                 top;
        int unsigned                 bot;
        res = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            top = (3 - fx) * a[8*k +: 8] + fx * b[8*k +: 8];
            bot = (3 - fx) * c[8*k +: 8] + fx * d[8*k +: 8];
            res[8*k +: 8] = 8'(((3 - fy) * top + fy * bot) / 9);
        end
        return res;
    endfunction

    task automatic queue_block(input int unsigned br, bc,
                               input logic [bu3_pkg::PIXEL_W-1:0] a, b, c, d,
                               input bit closes_run, closes_frame);
        upscaled_px_t px;
        for (int fy = 0; fy < 3; fy++) begin
            for (int fx = 0; fx < 3; fx++) begin
                px.x         = bu3_pkg::COORD_W'(3 * bc + fx);
                px.y         = bu3_pkg::COORD_W'(3 * br + fy);
                px.pixel     = blend3x(a, b, c, d, fy, fx);
                px.run_end   = closes_run && fy == 2 && fx == 2;
                px.frame_end = closes_frame && fy == 2 && fx == 2;
                pending_out_px.push_back(px);
            end
        end
    endtask

    task automatic predict_upscale(input logic [bu3_pkg::PIXEL_W-1:0] pix);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 c;
        int unsigned                 r;
        int unsigned                 last_blk;
        logic [bu3_pkg::PIXEL_W-1:0] up;
        logic [bu3_pkg::PIXEL_W-1:0] ul;
        logic [bu3_pkg::PIXEL_W-1:0] lft;
        bit                          last_col;
        bit                          last_row;
        bit [3:0]                    emit;
        w        = eff_size(low_cols_reg, MAX_LOW_COLUMNS);
        h        = eff_size(low_rows_reg, bu3_pkg::MAX_LOW_ROWS);
        c        = col_cnt < w - 1 ? col_cnt : w - 1;
        r        = row_cnt < h - 1 ? row_cnt : h - 1;
        up       = row_store[c];
        ul       = upper_left_px;
        lft      = left_px;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        emit[0]  = r >= 1 && c >= 1;
        emit[1]  = r >= 1 && last_col;
        emit[2]  = last_row && c >= 1;
        emit[3]  = last_row && last_col;
        last_blk = 0;
        for (int i = 0; i < 4; i++) begin
            if (emit[i]) last_blk = i;
        end
        if (emit[0]) queue_block(r - 1, c - 1, ul, up, lft, pix, last_blk == 0, 1'b0);
        if (emit[1]) queue_block(r - 1, c, up, up, pix, pix, last_blk == 1, 1'b0);
        if (emit[2]) queue_block(r, c - 1, lft, pix, lft, pix, last_blk == 2, 1'b0);
        if (emit[3]) queue_block(r, c, pix, pix, pix, pix, 1'b1, 1'b1);
        row_store[c]  = pix;
        upper_left_px = up;
        left_px       = pix;
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    // Pixels still needed to close the current frame at the present size.
    function automatic int unsigned frame_left();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        w = eff_size(low_cols_reg, MAX_LOW_COLUMNS);
        h = eff_size(low_rows_reg, bu3_pkg::MAX_LOW_ROWS);
        c = col_cnt < w - 1 ? col_cnt : w - 1;
        r = row_cnt < h - 1 ? row_cnt : h - 1;
        return (h - 1 - r) * w + (w - c);
    endfunction

    function automatic logic [bu3_pkg::PIXEL_W-1:0] rand_pixel();
        logic [bu3_pkg::PIXEL_W-1:0] p;
        p = $urandom;
        case ($urandom_range(0, 7))
            0: p = '1;
            1: p = '0;
            2: begin
                for (int k = 0; k < bu3_pkg::PIXEL_W / 8; k++) begin
                    p[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic queue_pixel(input logic [bu3_pkg::PIXEL_W-1:0] p);
        pixel_q.push_back(p);
        queued_count++;
    endtask

    task automatic queue_random_pixels(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) queue_pixel(rand_pixel());
    endtask

    task automatic write_reg(input bu3_pkg::cfg_index_t idx,
                             input logic [bu3_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == bu3_pkg::CFG_LOW_COLUMNS) low_cols_reg = val;
        else low_rows_reg = val;
        reg_writes++;
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || pending_out_px.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [bu3_pkg::CFG_DATA_W-1:0] rand_size();
        case ($urandom_range(0, 11))
            0:       return bu3_pkg::CFG_DATA_W'($urandom_range(0, 1));
            1:       return bu3_pkg::CFG_DATA_W'($urandom_range(1020, 2047));
            default: return bu3_pkg::CFG_DATA_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: %s", what);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_upscale(s_tdata);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0 || pixel_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 24);
                    end
                end
            end
        end
    end

    // Receiver: alternates between steady, random and sparse acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (ready_span == 0) begin
                ready_mode = rx_mode_t'($urandom_range(0, 2));
                ready_span = $urandom_range(20, 150);
            end else begin
                ready_span--;
            end
            case (ready_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= (ready_span % 6 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_px = '{x: m_tdata[bu3_pkg::COORD_W-1:0],
                       y: m_tdata[2*bu3_pkg::COORD_W-1:bu3_pkg::COORD_W],
                       pixel: m_tdata[2*bu3_pkg::COORD_W +: bu3_pkg::PIXEL_W],
                       run_end: m_tlast,
                       frame_end: m_tuser};
            if (pending_out_px.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction x=%0d y=%0d pixel=%h",
                                          got_px.x, got_px.y, got_px.pixel));
            end else begin
                want_px = pending_out_px.pop_front();
                checked_count++;
                if (got_px.x !== want_px.x || got_px.y !== want_px.y ||
                    got_px.pixel !== want_px.pixel || got_px.run_end !== want_px.run_end ||
                    got_px.frame_end !== want_px.frame_end) begin
                    report_mismatch($sformatf(
                        "exp x=%0d y=%0d px=%h l=%b f=%b, got x=%0d y=%0d px=%h l=%b f=%b",
                        want_px.x, want_px.y, want_px.pixel, want_px.run_end, want_px.frame_end,
                        got_px.x, got_px.y, got_px.pixel, got_px.run_end, got_px.frame_end));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_out_px.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned                    random_items;
        int unsigned                    n;
        logic [bu3_pkg::CFG_DATA_W-1:0] size_val;
        random_items = 0;
        for (int i = 0; i < MAX_LOW_COLUMNS; i++) row_store[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest image, extreme pixel values.
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(2));
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(2));
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h00FF_00FF);
        queue_pixel(32'hFF00_FF00);
        wait_idle();

        // Sizes below the minimum are raised to two.
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(0));
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(1));
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h0000_0000);
        queue_pixel(32'h8080_8080);
        queue_pixel(32'h7F7F_7F7F);
        wait_idle();

        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(3));
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(3));
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h1234_5678);
        queue_pixel(32'hFF00_0000);
        queue_pixel(32'h00FF_FFFF);
        queue_pixel(32'h8080_8080);
        queue_pixel(32'h7F7F_7F7F);
        queue_pixel(32'h0102_0304);
        queue_pixel(32'hFEFD_FCFB);
        wait_idle();

        // Shrink width, then height, part way through a frame.
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(4));
        queue_random_pixels(6);
        wait_idle();
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(2));
        queue_random_pixels(1);
        wait_idle();
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(2));
        queue_random_pixels(2);
        wait_idle();

        // Oversized width cut to the maximum, then the row is closed by a narrower width.
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(2047));
        queue_random_pixels(8);
        wait_idle();
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(2));
        queue_random_pixels(frame_left());
        wait_idle();

        // Tallest image, closed early by a lower height.
        write_reg(bu3_pkg::CFG_LOW_COLUMNS, bu3_pkg::CFG_DATA_W'(2));
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(bu3_pkg::MAX_LOW_ROWS));
        queue_random_pixels(8);
        wait_idle();
        write_reg(bu3_pkg::CFG_LOW_ROWS, bu3_pkg::CFG_DATA_W'(2));
        queue_random_pixels(frame_left());
        wait_idle();

        // Random small frames; some are cut short by a size change.
        // The width only grows between frames so that every row entry read was written.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                size_val = rand_size();
                if ((col_cnt == 0 && row_cnt == 0) ||
                    eff_size(size_val, MAX_LOW_COLUMNS) <=
                    eff_size(low_cols_reg, MAX_LOW_COLUMNS)) begin
                    write_reg(bu3_pkg::CFG_LOW_COLUMNS, size_val);
                end
            end
            if ($urandom_range(0, 3) != 0) write_reg(bu3_pkg::CFG_LOW_ROWS, rand_size());
            n = frame_left();
            if (n > 40 || $urandom_range(0, 3) == 0) n = $urandom_range(1, n > 40 ? 40 : n);
            queue_random_pixels(n);
            random_items += n;
            wait_idle();
        end

        $display("Checked %0d output pixels from %0d input pixels across %0d register writes,",
                 checked_count, accepted_count, reg_writes);
        $display("covering minimum and maximum sizes, clamped sizes and mid-frame resizing.");
        if (mismatch_count == 0 && pending_out_px.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
